@@ hdl/etd_pkg.sv @@
// ----------------------------------------------------------------------------
// etd_pkg
// Widths, calendar constants, reciprocal factors and the per-stage load
// struct shared by the epoch-seconds-to-date/time pipeline.
// ----------------------------------------------------------------------------
package etd_pkg;

  localparam int EPOCH_W  = 32;
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int MDAY_W   = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;

  localparam int DAYS_W = 16;
  localparam int TOD_W  = 17;
  localparam int ADJ_W  = 21;
  localparam int NY_W   = 30;
  localparam int YR_W   = 12;
  localparam int DOY_W  = 9;
  localparam int MINS_W = 11;
  localparam int CENT_W = 5;
  localparam int MO_W   = 4;

  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_MIN  = 60;
  localparam int MINS_PER_HOUR = 60;
  localparam int DAY_SHIFT     = 719469;
  localparam int CENTURY_X1000 = 36524250;
  localparam int YEAR_X1000    = 365250;
  localparam int MONTH_X1000   = 30600;
  localparam int SCALE         = 1000;
  localparam int YEAR_BIAS     = 200;
  localparam int MONTH_BIAS    = 500;

  localparam int YEAR_DAYS    = YEAR_X1000 / SCALE;
  localparam int LEAP_SHIFT   = 2;
  localparam int MARCH_OFFSET = 3;
  localparam int YEAR_TURN    = 9;
  localparam int MONTHS       = 12;

  // century count over the reachable day range is CENT_BASE, +1 or +2
  localparam int CENT_BASE     = (DAY_SHIFT * SCALE - YEAR_BIAS) / CENTURY_X1000;
  localparam int CENT_MID_DAYS = ((CENT_BASE + 1) * CENTURY_X1000 + YEAR_BIAS + SCALE - 1)
                                 / SCALE - DAY_SHIFT;
  localparam int CENT_TOP_DAYS = ((CENT_BASE + 2) * CENTURY_X1000 + YEAR_BIAS + SCALE - 1)
                                 / SCALE - DAY_SHIFT;

  // seconds per day split into a power of two and an odd factor
  localparam int DAY_POW2    = 7;
  localparam int DAY_ODD     = SECS_PER_DAY >> DAY_POW2;
  localparam int DAY_X_W     = EPOCH_W - DAY_POW2;
  localparam int DAY_K       = 35;
  localparam int DAY_RECIP_W = 26;
  localparam logic [DAY_RECIP_W-1:0] DAY_RECIP =
    DAY_RECIP_W'(((64'd1 << DAY_K) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD));
  localparam int DAY_PROD_W  = DAY_X_W + DAY_RECIP_W;

  localparam int YR_K       = 49;
  localparam int YR_RECIP_W = 31;
  localparam logic [YR_RECIP_W-1:0] YR_RECIP =
    YR_RECIP_W'(((64'd1 << YR_K) + 64'(YEAR_X1000) - 64'd1) / 64'(YEAR_X1000));
  localparam int YR_PROD_W  = NY_W + YR_RECIP_W;

  localparam int MIN_K       = 23;
  localparam int MIN_RECIP_W = 18;
  localparam logic [MIN_RECIP_W-1:0] MIN_RECIP =
    MIN_RECIP_W'(((64'd1 << MIN_K) + 64'(SECS_PER_MIN) - 64'd1) / 64'(SECS_PER_MIN));
  localparam int MIN_PROD_W  = TOD_W + MIN_RECIP_W;

  localparam int HR_K       = 17;
  localparam int HR_RECIP_W = 12;
  localparam logic [HR_RECIP_W-1:0] HR_RECIP =
    HR_RECIP_W'(((64'd1 << HR_K) + 64'(MINS_PER_HOUR) - 64'd1) / 64'(MINS_PER_HOUR));
  localparam int HR_PROD_W  = MINS_W + HR_RECIP_W;

  // first day-of-year of each March-based month, as a threshold on doy
  function automatic logic [DOY_W-1:0] month_first(input int k);
    month_first = DOY_W'((k * MONTH_X1000 + MONTH_BIAS + SCALE - 1) / SCALE);
  endfunction

  // days before each March-based month
  function automatic logic [DOY_W-1:0] month_start(input int k);
    if (k == 0) begin
      month_start = '0;
    end else begin
      month_start = DOY_W'((k * MONTH_X1000 - MONTH_BIAS + SCALE - 1) / SCALE);
    end
  endfunction

  localparam logic [DOY_W-1:0] MONTH_FIRST [MONTHS] = '{
    month_first(0), month_first(1), month_first(2), month_first(3),
    month_first(4), month_first(5), month_first(6), month_first(7),
    month_first(8), month_first(9), month_first(10), month_first(11)
  };

  localparam logic [DOY_W-1:0] MONTH_START [MONTHS] = '{
    month_start(0), month_start(1), month_start(2), month_start(3),
    month_start(4), month_start(5), month_start(6), month_start(7),
    month_start(8), month_start(9), month_start(10), month_start(11)
  };

  localparam int STAGES = 6;

  typedef struct packed {
    logic a;
    logic b;
    logic c;
    logic d;
    logic e;
    logic f;
  } etd_load_t;

endpackage

@@ hdl/epoch_seconds_to_date_time.sv @@
// ----------------------------------------------------------------------------
// epoch_seconds_to_date_time
// Converts a 32-bit Unix second count into UTC year, month, day of month,
// hour, minute and second, one transaction per clock while out_stall is low.
// ----------------------------------------------------------------------------
// Takes one timestamp per cycle while in_stall is low. The six register
// stages follow the dependent chain of the date: the reciprocal multiply for
// the division by 86400, the back-multiply for the time of day with the
// century correction, the scale by 1000, the reciprocal multiply for the
// division by 365.25, the day of year, and the month lookup with the
// March-based remap. Hour, minute and second run beside the date and are
// delayed to the same depth. Every 32-bit input is valid, up to 2106-02-07
// 06:28:15. When out_stall is held, empty stages still fill, so in_stall
// rises only once every stage holds a transaction.
module epoch_seconds_to_date_time (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [etd_pkg::EPOCH_W-1:0]    in_epoch_seconds,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [etd_pkg::YEAR_W-1:0]     out_year,
  output logic [etd_pkg::MONTH_W-1:0]    out_month,
  output logic [etd_pkg::MDAY_W-1:0]     out_day_of_month,
  output logic [etd_pkg::HOUR_W-1:0]     out_hour,
  output logic [etd_pkg::MINUTE_W-1:0]   out_minute,
  output logic [etd_pkg::SECOND_W-1:0]   out_second
);

  etd_pkg::etd_load_t          ld;
  logic [etd_pkg::ADJ_W-1:0]   adj;
  logic [etd_pkg::TOD_W-1:0]   tod;

  etd_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ld        (ld)
  );

  etd_day_split u_split (
    .clk  (clk),
    .ld   (ld),
    .secs (in_epoch_seconds),
    .adj  (adj),
    .tod  (tod)
  );

  etd_date_path u_date (
    .clk          (clk),
    .ld           (ld),
    .adj          (adj),
    .year         (out_year),
    .month        (out_month),
    .day_of_month (out_day_of_month)
  );

  etd_clock_path u_clock (
    .clk    (clk),
    .ld     (ld),
    .tod    (tod),
    .hour   (out_hour),
    .minute (out_minute),
    .second (out_second)
  );

endmodule

@@ hdl/etd_pipe_ctrl.sv @@
// ----------------------------------------------------------------------------
// etd_pipe_ctrl
// Valid bits for the six pipeline stages and per-stage load enables that
// let bubbles collapse while the output is stalled.
// ----------------------------------------------------------------------------
module etd_pipe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output etd_pkg::etd_load_t ld
);

  logic [etd_pkg::STAGES-1:0] vld_r;
  logic [etd_pkg::STAGES-1:0] vld_nxt;
  logic [etd_pkg::STAGES-1:0] load;

  always_comb begin
    load[etd_pkg::STAGES-1] = !vld_r[etd_pkg::STAGES-1] || !out_stall;
    for (int k = etd_pkg::STAGES - 2; k >= 0; k--) begin
      load[k] = !vld_r[k] || load[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (load[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < etd_pkg::STAGES; k++) begin
      if (load[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !load[0];
  assign out_valid = vld_r[etd_pkg::STAGES-1];
  assign ld.a      = load[0];
  assign ld.b      = load[1];
  assign ld.c      = load[2];
  assign ld.d      = load[3];
  assign ld.e      = load[4];
  assign ld.f      = load[5];

endmodule

@@ hdl/etd_day_split.sv @@
// ----------------------------------------------------------------------------
// etd_day_split
// Splits the second count into whole days and time of day, and forms the
// century-corrected day number.
// ----------------------------------------------------------------------------
module etd_day_split (
  input  logic                         clk,
  input  etd_pkg::etd_load_t           ld,
  input  logic [etd_pkg::EPOCH_W-1:0]  secs,
  output logic [etd_pkg::ADJ_W-1:0]    adj,
  output logic [etd_pkg::TOD_W-1:0]    tod
);

  logic [etd_pkg::EPOCH_W-1:0]    secs_a_r;
  logic [etd_pkg::DAYS_W-1:0]     days_a_r;
  logic [etd_pkg::DAYS_W-1:0]     days_a_nxt;
  logic [etd_pkg::DAY_PROD_W-1:0] day_prod;
  logic [etd_pkg::ADJ_W-1:0]      adj_b_r;
  logic [etd_pkg::ADJ_W-1:0]      adj_b_nxt;
  logic [etd_pkg::TOD_W-1:0]      tod_b_r;
  logic [etd_pkg::TOD_W-1:0]      tod_b_nxt;
  logic [etd_pkg::EPOCH_W-1:0]    day_base;
  logic [etd_pkg::CENT_W-1:0]     cent;

  always_comb begin
    day_prod   = etd_pkg::DAY_PROD_W'(secs >> etd_pkg::DAY_POW2)
                 * etd_pkg::DAY_PROD_W'(etd_pkg::DAY_RECIP);
    days_a_nxt = etd_pkg::DAYS_W'(day_prod >> etd_pkg::DAY_K);
  end

  always_ff @(posedge clk) begin
    if (ld.a) begin
      secs_a_r <= secs;
      days_a_r <= days_a_nxt;
    end
  end

  always_comb begin
    day_base  = etd_pkg::EPOCH_W'(days_a_r) * etd_pkg::EPOCH_W'(etd_pkg::SECS_PER_DAY);
    tod_b_nxt = etd_pkg::TOD_W'(secs_a_r - day_base);
    cent      = etd_pkg::CENT_W'(etd_pkg::CENT_BASE)
              + etd_pkg::CENT_W'(days_a_r >= etd_pkg::DAYS_W'(etd_pkg::CENT_MID_DAYS))
              + etd_pkg::CENT_W'(days_a_r >= etd_pkg::DAYS_W'(etd_pkg::CENT_TOP_DAYS));
    adj_b_nxt = etd_pkg::ADJ_W'(days_a_r) + etd_pkg::ADJ_W'(etd_pkg::DAY_SHIFT)
              + etd_pkg::ADJ_W'(cent) - etd_pkg::ADJ_W'(cent >> 2);
  end

  always_ff @(posedge clk) begin
    if (ld.b) begin
      adj_b_r <= adj_b_nxt;
      tod_b_r <= tod_b_nxt;
    end
  end

  assign adj = adj_b_r;
  assign tod = tod_b_r;

endmodule

@@ hdl/etd_date_path.sv @@
// ----------------------------------------------------------------------------
// etd_date_path
// Century-corrected day number to Gregorian year, month and day of month:
// scaled year divide, day of year, month lookup and March-based remap.
// ----------------------------------------------------------------------------
module etd_date_path (
  input  logic                          clk,
  input  etd_pkg::etd_load_t            ld,
  input  logic [etd_pkg::ADJ_W-1:0]     adj,
  output logic [etd_pkg::YEAR_W-1:0]    year,
  output logic [etd_pkg::MONTH_W-1:0]   month,
  output logic [etd_pkg::MDAY_W-1:0]    day_of_month
);

  logic [etd_pkg::NY_W-1:0]      ny_c_r;
  logic [etd_pkg::NY_W-1:0]      ny_c_nxt;
  logic [etd_pkg::ADJ_W-1:0]     adj_c_r;
  logic [etd_pkg::YR_PROD_W-1:0] yr_prod;
  logic [etd_pkg::YR_W-1:0]      yr_d_r;
  logic [etd_pkg::YR_W-1:0]      yr_d_nxt;
  logic [etd_pkg::ADJ_W-1:0]     adj_d_r;
  logic [etd_pkg::ADJ_W-1:0]     year_days;
  logic [etd_pkg::DOY_W-1:0]     doy_e_r;
  logic [etd_pkg::DOY_W-1:0]     doy_e_nxt;
  logic [etd_pkg::YR_W-1:0]      yr_e_r;
  logic [etd_pkg::MO_W-1:0]      mo;
  logic [etd_pkg::DOY_W-1:0]     mday_full;
  logic [etd_pkg::YEAR_W-1:0]    year_r;
  logic [etd_pkg::YEAR_W-1:0]    year_nxt;
  logic [etd_pkg::MONTH_W-1:0]   month_r;
  logic [etd_pkg::MONTH_W-1:0]   month_nxt;
  logic [etd_pkg::MDAY_W-1:0]    mday_r;
  logic [etd_pkg::MDAY_W-1:0]    mday_nxt;

  assign ny_c_nxt = etd_pkg::NY_W'(32'(adj) * 32'(etd_pkg::SCALE) - 32'(etd_pkg::YEAR_BIAS));

  always_ff @(posedge clk) begin
    if (ld.c) begin
      ny_c_r  <= ny_c_nxt;
      adj_c_r <= adj;
    end
  end

  always_comb begin
    yr_prod  = etd_pkg::YR_PROD_W'(ny_c_r) * etd_pkg::YR_PROD_W'(etd_pkg::YR_RECIP);
    yr_d_nxt = etd_pkg::YR_W'(yr_prod >> etd_pkg::YR_K);
  end

  always_ff @(posedge clk) begin
    if (ld.d) begin
      yr_d_r  <= yr_d_nxt;
      adj_d_r <= adj_c_r;
    end
  end

  always_comb begin
    year_days = etd_pkg::ADJ_W'(yr_d_r) * etd_pkg::ADJ_W'(etd_pkg::YEAR_DAYS)
              + etd_pkg::ADJ_W'(yr_d_r >> etd_pkg::LEAP_SHIFT);
    doy_e_nxt = etd_pkg::DOY_W'(adj_d_r - year_days);
  end

  always_ff @(posedge clk) begin
    if (ld.e) begin
      doy_e_r <= doy_e_nxt;
      yr_e_r  <= yr_d_r;
    end
  end

  always_comb begin
    mo = '0;
    for (int k = 1; k < etd_pkg::MONTHS; k++) begin
      mo = mo + etd_pkg::MO_W'(doy_e_r >= etd_pkg::MONTH_FIRST[k]);
    end
    mday_full = doy_e_r - etd_pkg::MONTH_START[mo];
    mday_nxt  = etd_pkg::MDAY_W'(mday_full);
    if (mo <= etd_pkg::MO_W'(etd_pkg::YEAR_TURN)) begin
      month_nxt = etd_pkg::MONTH_W'(mo + etd_pkg::MO_W'(etd_pkg::MARCH_OFFSET));
      year_nxt  = etd_pkg::YEAR_W'(yr_e_r);
    end else begin
      month_nxt = etd_pkg::MONTH_W'(mo - etd_pkg::MO_W'(etd_pkg::YEAR_TURN));
      year_nxt  = etd_pkg::YEAR_W'(yr_e_r) + etd_pkg::YEAR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ld.f) begin
      year_r  <= year_nxt;
      month_r <= month_nxt;
      mday_r  <= mday_nxt;
    end
  end

  assign year         = year_r;
  assign month        = month_r;
  assign day_of_month = mday_r;

endmodule

@@ hdl/etd_clock_path.sv @@
// ----------------------------------------------------------------------------
// etd_clock_path
// Time of day in seconds to hour, minute and second, aligned with the
// date stages.
// ----------------------------------------------------------------------------
module etd_clock_path (
  input  logic                           clk,
  input  etd_pkg::etd_load_t             ld,
  input  logic [etd_pkg::TOD_W-1:0]      tod,
  output logic [etd_pkg::HOUR_W-1:0]     hour,
  output logic [etd_pkg::MINUTE_W-1:0]   minute,
  output logic [etd_pkg::SECOND_W-1:0]   second
);

  logic [etd_pkg::MIN_PROD_W-1:0] min_prod;
  logic [etd_pkg::TOD_W-1:0]      tod_c_r;
  logic [etd_pkg::MINS_W-1:0]     mins_c_r;
  logic [etd_pkg::MINS_W-1:0]     mins_c_nxt;
  logic [etd_pkg::HR_PROD_W-1:0]  hr_prod;
  logic [etd_pkg::MINS_W-1:0]     mins_d_r;
  logic [etd_pkg::HOUR_W-1:0]     hour_d_r;
  logic [etd_pkg::HOUR_W-1:0]     hour_d_nxt;
  logic [etd_pkg::SECOND_W-1:0]   sec_d_r;
  logic [etd_pkg::SECOND_W-1:0]   sec_d_nxt;
  logic [etd_pkg::HOUR_W-1:0]     hour_e_r;
  logic [etd_pkg::MINUTE_W-1:0]   minute_e_r;
  logic [etd_pkg::MINUTE_W-1:0]   minute_e_nxt;
  logic [etd_pkg::SECOND_W-1:0]   sec_e_r;
  logic [etd_pkg::HOUR_W-1:0]     hour_r;
  logic [etd_pkg::MINUTE_W-1:0]   minute_r;
  logic [etd_pkg::SECOND_W-1:0]   second_r;

  always_comb begin
    min_prod   = etd_pkg::MIN_PROD_W'(tod) * etd_pkg::MIN_PROD_W'(etd_pkg::MIN_RECIP);
    mins_c_nxt = etd_pkg::MINS_W'(min_prod >> etd_pkg::MIN_K);
  end

  always_ff @(posedge clk) begin
    if (ld.c) begin
      tod_c_r  <= tod;
      mins_c_r <= mins_c_nxt;
    end
  end

  always_comb begin
    sec_d_nxt  = etd_pkg::SECOND_W'(tod_c_r - etd_pkg::TOD_W'(mins_c_r)
                                    * etd_pkg::TOD_W'(etd_pkg::SECS_PER_MIN));
    hr_prod    = etd_pkg::HR_PROD_W'(mins_c_r) * etd_pkg::HR_PROD_W'(etd_pkg::HR_RECIP);
    hour_d_nxt = etd_pkg::HOUR_W'(hr_prod >> etd_pkg::HR_K);
  end

  always_ff @(posedge clk) begin
    if (ld.d) begin
      mins_d_r <= mins_c_r;
      hour_d_r <= hour_d_nxt;
      sec_d_r  <= sec_d_nxt;
    end
  end

  assign minute_e_nxt = etd_pkg::MINUTE_W'(mins_d_r - etd_pkg::MINS_W'(hour_d_r)
                                           * etd_pkg::MINS_W'(etd_pkg::MINS_PER_HOUR));

  always_ff @(posedge clk) begin
    if (ld.e) begin
      hour_e_r   <= hour_d_r;
      minute_e_r <= minute_e_nxt;
      sec_e_r    <= sec_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.f) begin
      hour_r   <= hour_e_r;
      minute_r <= minute_e_r;
      second_r <= sec_e_r;
    end
  end

  assign hour   = hour_r;
  assign minute = minute_r;
  assign second = second_r;

endmodule

@@ dv/tb_epoch_seconds_to_date_time.sv @@
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_date_time
// Self-checking bench for the epoch-seconds to UTC date/time converter.
// ----------------------------------------------------------------------------
// Drives directed timestamps (range ends, day, month and year turns, leap and
// non-leap February ends), then random timestamps biased toward day
// boundaries and both ends of the range. Each accepted input is converted by
// a bench-side calendar model and queued; each accepted result is compared
// field by field against the oldest queued date. Sender and receiver idle
// at random in the first two of three phases, with a full drain between them.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_date_time;

  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned PHASE_ITEMS = 600;
  localparam int unsigned PAUSE_EVERY = 200;
  localparam int unsigned LAST_DAY    = 49710;

  localparam bit [31:0] C_DAY_SECS  = 32'd86400;
  localparam bit [31:0] C_HOUR_SECS = 32'd3600;
  localparam bit [31:0] C_MIN_SECS  = 32'd60;
  localparam bit [31:0] C_DAY_SHIFT = 32'd719469;
  localparam bit [31:0] C_CENTURY   = 32'd36524250;
  localparam bit [31:0] C_YEAR      = 32'd365250;
  localparam bit [31:0] C_MONTH     = 32'd30600;
  localparam bit [31:0] C_SCALE     = 32'd1000;
  localparam bit [31:0] C_YEAR_BIAS = 32'd200;
  localparam bit [31:0] C_MON_BIAS  = 32'd500;
  localparam bit [31:0] C_MAR_SHIFT = 32'd3;
  localparam bit [31:0] C_YEAR_TURN = 32'd9;

  typedef struct packed {
    logic [etd_pkg::YEAR_W-1:0]   year;
    logic [etd_pkg::MONTH_W-1:0]  month;
    logic [etd_pkg::MDAY_W-1:0]   day_of_month;
    logic [etd_pkg::HOUR_W-1:0]   hour;
    logic [etd_pkg::MINUTE_W-1:0] minute;
    logic [etd_pkg::SECOND_W-1:0] second;
  } date_time_t;

  typedef struct packed {
    logic [etd_pkg::EPOCH_W-1:0] epoch;
    date_time_t                  dt;
  } dated_epoch_t;

  class calendar_checker;
    dated_epoch_t expected_dates[$];
    int unsigned  mismatches;

    function date_time_t epoch_to_calendar(bit [31:0] secs);
      bit [31:0] tod, days, cent, adj, yr, doy, mo, mday, mon, yy;
      date_time_t r;
      tod  = secs % C_DAY_SECS;
      days = secs / C_DAY_SECS + C_DAY_SHIFT;
      cent = (days * C_SCALE - C_YEAR_BIAS) / C_CENTURY;
      adj  = days + cent - cent / 32'd4;
      yr   = (adj * C_SCALE - C_YEAR_BIAS) / C_YEAR;
      doy  = adj - (C_YEAR * yr) / C_SCALE;
      mo   = (doy * C_SCALE - C_MON_BIAS) / C_MONTH;
      mday = (doy * C_SCALE - C_MONTH * mo + C_MON_BIAS) / C_SCALE;
      if (mo <= C_YEAR_TURN) begin
        mon = mo + C_MAR_SHIFT;
        yy  = yr;
      end else begin
        mon = mo - C_YEAR_TURN;
        yy  = yr + 32'd1;
      end
      r.year         = etd_pkg::YEAR_W'(yy);
      r.month        = etd_pkg::MONTH_W'(mon);
      r.day_of_month = etd_pkg::MDAY_W'(mday);
      r.hour         = etd_pkg::HOUR_W'(tod / C_HOUR_SECS);
      r.minute       = etd_pkg::MINUTE_W'((tod % C_HOUR_SECS) / C_MIN_SECS);
      r.second       = etd_pkg::SECOND_W'(tod % C_MIN_SECS);
      return r;
    endfunction

    function void note_epoch(bit [31:0] secs);
      dated_epoch_t e;
      e.epoch = secs;
      e.dt    = epoch_to_calendar(secs);
      expected_dates.push_back(e);
    endfunction

    function void check_result(date_time_t got);
      dated_epoch_t e;
      if (expected_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result %0d-%0d-%0d %0d:%0d:%0d", got.year, got.month,
                   got.day_of_month, got.hour, got.minute, got.second);
        return;
      end
      e = expected_dates.pop_front();
      if (got.year !== e.dt.year || got.month !== e.dt.month ||
          got.day_of_month !== e.dt.day_of_month || got.hour !== e.dt.hour ||
          got.minute !== e.dt.minute || got.second !== e.dt.second) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch for %0d: exp %0d-%0d-%0d %0d:%0d:%0d got %0d-%0d-%0d %0d:%0d:%0d",
                   e.epoch, e.dt.year, e.dt.month, e.dt.day_of_month, e.dt.hour,
                   e.dt.minute, e.dt.second, got.year, got.month, got.day_of_month,
                   got.hour, got.minute, got.second);
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [etd_pkg::EPOCH_W-1:0]  in_epoch_seconds;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [etd_pkg::YEAR_W-1:0]   out_year;
  logic [etd_pkg::MONTH_W-1:0]  out_month;
  logic [etd_pkg::MDAY_W-1:0]   out_day_of_month;
  logic [etd_pkg::HOUR_W-1:0]   out_hour;
  logic [etd_pkg::MINUTE_W-1:0] out_minute;
  logic [etd_pkg::SECOND_W-1:0] out_second;

  int unsigned     send_idle_pct = 34;
  int unsigned     recv_idle_pct = 52;
  int unsigned     quiet_cycles  = 0;
  calendar_checker dates        = new();

  epoch_seconds_to_date_time u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        dates.note_epoch(in_epoch_seconds);
      end
      if (out_valid && !out_stall) begin
        dates.check_result(date_time_t'({out_year, out_month, out_day_of_month,
                                         out_hour, out_minute, out_second}));
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_epoch(input logic [etd_pkg::EPOCH_W-1:0] secs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_epoch_seconds <= secs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (dates.expected_dates.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [etd_pkg::EPOCH_W-1:0] pick_epoch();
    int unsigned d;
    int unsigned off;
    d   = $urandom_range(LAST_DAY);
    off = $urandom_range(3);
    case ($urandom_range(4))
      0, 1: return $urandom();
      2: begin
        if (d == 0 || $urandom_range(1)) return d * C_DAY_SECS + off;
        return d * C_DAY_SECS - 1 - off;
      end
      3: return 32'hFFFF_FFFF - $urandom_range(2_000_000);
      default: return $urandom_range(2_000_000);
    endcase
  endfunction

  logic [etd_pkg::EPOCH_W-1:0] directed_epochs[$] = '{
    32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
    32'd68169600, 32'd94694399, 32'd94694400, 32'd946684799, 32'd946684800,
    32'd951782400, 32'd951868800, 32'd2147483647, 32'd2147483648,
    32'd4107542399, 32'd4107542400, 32'd4294944000, 32'hAAAA_AAAA,
    32'h5555_5555, 32'hFFFF_FFFE, 32'hFFFF_FFFF
  };

  int unsigned send_pct_by_phase[3] = '{34, 52, 0};
  int unsigned recv_pct_by_phase[3] = '{52, 34, 0};

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_epoch_seconds = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_epochs[i]) send_epoch(directed_epochs[i]);
    hold_until_drained();

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = send_pct_by_phase[p];
      recv_idle_pct = recv_pct_by_phase[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_epoch(pick_epoch());
        if (n % PAUSE_EVERY == PAUSE_EVERY - 1) hold_until_drained();
      end
      hold_until_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (dates.mismatches == 0 && dates.expected_dates.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
